[rtl/nusc_pkg.sv]
`timescale 1ns / 1ps
// nusc_pkg: shared types and constants for the nal unit splitter/classifier
// no dependencies; imported by nusc_front, nusc_queue, nusc_back and the top level

package nusc_pkg;

  // fixed output field widths
  localparam int OUT_W = 32;
  localparam int HDR_N = 5;

  // queue between the byte front and the record back
  localparam int QDEPTH = 4;
  localparam int QIDX_W = 2;

  // codec_select codes
  localparam logic [1:0] CODEC_H264 = 2'd0;
  localparam logic [1:0] CODEC_H265 = 2'd1;
  localparam logic [1:0] CODEC_H266 = 2'd2;

  // register indexes
  localparam logic REG_CODEC_SELECT = 1'b0;

  // unit kinds
  localparam logic [2:0] KIND_VCL     = 3'd0;
  localparam logic [2:0] KIND_VPS     = 3'd1;
  localparam logic [2:0] KIND_SPS     = 3'd2;
  localparam logic [2:0] KIND_PPS     = 3'd3;
  localparam logic [2:0] KIND_SPS_EXT = 3'd4;
  localparam logic [2:0] KIND_APS     = 3'd5;
  localparam logic [2:0] KIND_OTHER   = 3'd6;

  // avc nal types
  localparam logic [4:0] AVC_VCL_LIMIT = 5'd6;
  localparam logic [4:0] AVC_SPS       = 5'd7;
  localparam logic [4:0] AVC_PPS       = 5'd8;
  localparam logic [4:0] AVC_SPS_EXT   = 5'd13;

  // hevc nal types
  localparam logic [6:0] HEVC_VPS = 7'd32;
  localparam logic [6:0] HEVC_SPS = 7'd33;
  localparam logic [6:0] HEVC_PPS = 7'd34;

  // vvc nal types
  localparam logic [4:0] VVC_VCL_LIMIT = 5'd12;
  localparam logic [4:0] VVC_VPS       = 5'd14;
  localparam logic [4:0] VVC_SPS       = 5'd15;
  localparam logic [4:0] VVC_PPS       = 5'd16;
  localparam logic [4:0] VVC_APS_A     = 5'd17;
  localparam logic [4:0] VVC_APS_B     = 5'd18;

  // one closed unit, header not yet decoded
  typedef struct packed {
    logic [OUT_W-1:0]          start;
    logic [OUT_W-1:0]          length;
    logic [2:0]                len_sat;  // length saturated at 7
    logic [HDR_N-1:0][7:0]     hdr;      // unit bytes at offsets 2..6
  } unit_rec_t;

  // everything one byte closes: at most two units
  typedef struct packed {
    logic      vld_a;
    logic      vld_b;
    unit_rec_t rec_a;
    unit_rec_t rec_b;
  } rec_pair_t;

endpackage

[rtl/nusc_byte_if.sv]
`timescale 1ns / 1ps
// nusc_byte_if: input byte channel, valid/ready with byte payload
// no dependencies

interface nusc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

[rtl/nusc_unit_if.sv]
`timescale 1ns / 1ps
// nusc_unit_if: output unit record channel, valid/ready with record payload
// no dependencies

interface nusc_unit_if;
  logic              valid;
  logic              ready;
  logic [31:0]       unit_start;
  logic [31:0]       unit_length;
  logic [2:0]        unit_kind;
  logic signed [3:0] temporal_id;
  logic [7:0]        param_set_id;
  logic              last_of_run;

  modport source (output valid, output unit_start, output unit_length, output unit_kind,
                  output temporal_id, output param_set_id, output last_of_run,
                  input ready);
  modport sink (input valid, input unit_start, input unit_length, input unit_kind,
                input temporal_id, input param_set_id, input last_of_run,
                output ready);
endinterface

[rtl/nusc_front.sv]
`timescale 1ns / 1ps
// nusc_front: start code scan and unit boundary tracking, one byte per cycle
// unless q_full; uses nusc_pkg, nusc_byte_if; feeds closed units to nusc_queue

module nusc_front import nusc_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  nusc_byte_if.sink  in_ch,
  input  logic       q_full,
  output logic       push,
  output rec_pair_t  push_data
);

  localparam int PW = POSITION_BITS;

  logic [PW-1:0]          byte_count, byte_count_next;
  logic [PW-1:0]          unit_begin, unit_begin_next;
  logic [1:0]             zero_run, zero_run_next;
  logic [2:0]             offset_in_unit, offset_in_unit_next;
  logic [HDR_N-1:0][7:0]  header_bytes, header_bytes_next;

  logic                   accept;
  logic [HDR_N-1:0][7:0]  hdr_w;
  logic [2:0]             off_inc;
  logic                   sc_hit, close_a, close_b;
  logic [PW-1:0]          span, len_a, len_end, len_b, sc_pos;

  // pack a unit into a queue record
  function automatic unit_rec_t make_rec(input logic [PW-1:0] beg,
                                         input logic [PW-1:0] len,
                                         input logic [HDR_N-1:0][7:0] hdr);
    logic [PW+OUT_W-1:0] beg_x;
    logic [PW+OUT_W-1:0] len_x;
    unit_rec_t           r;
    beg_x     = {{OUT_W{1'b0}}, beg};
    len_x     = {{OUT_W{1'b0}}, len};
    r.start   = beg_x[OUT_W-1:0];
    r.length  = len_x[OUT_W-1:0];
    r.len_sat = (|len[PW-1:3]) ? 3'd7 : len[2:0];
    r.hdr     = hdr;
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // byte bookkeeping and boundary decisions
  always_comb begin
    hdr_w = header_bytes;
    if (offset_in_unit >= 3'd2 && offset_in_unit <= 3'd6) begin
      hdr_w[offset_in_unit - 3'd2] = in_ch.data_byte;
    end
    off_inc = (offset_in_unit != 3'd7) ? offset_in_unit + 3'd1 : offset_in_unit;

    sc_hit  = (zero_run == 2'd2) && (in_ch.data_byte == 8'd1);
    sc_pos  = byte_count - PW'(2);
    span    = byte_count - unit_begin;
    len_a   = span - PW'(2);
    len_end = span + PW'(1);
    close_a = sc_hit && (len_a >= PW'(2));

    // final unit either runs from the start code just seen or from the old start
    len_b   = close_a ? PW'(3) : len_end;
    close_b = in_ch.end_of_stream && (close_a || (len_end >= PW'(2)));

    unit_begin_next     = close_a ? sc_pos : unit_begin;
    offset_in_unit_next = close_a ? 3'd3 : off_inc;
    header_bytes_next   = close_a ? (HDR_N * 8)'(8'd1) : hdr_w;
    zero_run_next       = (in_ch.data_byte != 8'd0) ? 2'd0 :
                          (zero_run != 2'd2) ? zero_run + 2'd1 : zero_run;
    byte_count_next     = byte_count + PW'(1);

    push_data.vld_a = close_a;
    push_data.vld_b = close_b;
    push_data.rec_a = make_rec(unit_begin, len_a, hdr_w);
    push_data.rec_b = make_rec(unit_begin_next, len_b, header_bytes_next);
    push            = accept && (close_a || close_b);
  end

  // stream state, cleared again after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      unit_begin     <= '0;
      zero_run       <= '0;
      offset_in_unit <= '0;
      header_bytes   <= '0;
    end else if (accept) begin
      if (in_ch.end_of_stream) begin
        byte_count     <= '0;
        unit_begin     <= '0;
        zero_run       <= '0;
        offset_in_unit <= '0;
        header_bytes   <= '0;
      end else begin
        byte_count     <= byte_count_next;
        unit_begin     <= unit_begin_next;
        zero_run       <= zero_run_next;
        offset_in_unit <= offset_in_unit_next;
        header_bytes   <= header_bytes_next;
      end
    end
  end

endmodule

[rtl/nusc_queue.sv]
`timescale 1ns / 1ps
// nusc_queue: short fifo of closed-unit records between front and back
// depends on nusc_pkg

module nusc_queue import nusc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rec_pair_t wdata,
  output logic      full,
  input  logic      pop,
  output rec_pair_t rdata,
  output logic      empty
);

  rec_pair_t         slots [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr, rd_ptr;
  logic [QIDX_W:0]   count;

  assign full  = (count == (QIDX_W + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // record storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QIDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QIDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QIDX_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QIDX_W + 1)'(1);
      end
    end
  end

endmodule

[rtl/nusc_back.sv]
`timescale 1ns / 1ps
// nusc_back: header decode and registered record output, one record per cycle
// unless stalled; depends on nusc_pkg and nusc_unit_if; drains nusc_queue

module nusc_back import nusc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rec_pair_t   head,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic [1:0]  codec_select,
  nusc_unit_if.source out_ch
);

  logic              sel, sel_next;
  logic              take_a, is_last, load;
  unit_rec_t         cand;
  logic [2:0]        kind;
  logic signed [3:0] tid;
  logic [7:0]        psid;

  // unit byte at offset k, zero outside offsets 2..6 or at or past the unit length
  function automatic logic [7:0] ubyte(input unit_rec_t r, input logic [2:0] k);
    logic [7:0] b;
    b = 8'd0;
    if (k >= 3'd2 && k <= 3'd6 && k < r.len_sat) begin
      b = r.hdr[k - 3'd2];
    end
    return b;
  endfunction

  // header decode under the selected codec rules
  always_comb begin
    logic       short_sc;
    logic [7:0] h0, h1, h2;
    short_sc = (ubyte(cand, 3'd2) == 8'd1);
    h0   = short_sc ? ubyte(cand, 3'd3) : ubyte(cand, 3'd4);
    h1   = short_sc ? ubyte(cand, 3'd4) : ubyte(cand, 3'd5);
    h2   = short_sc ? ubyte(cand, 3'd5) : ubyte(cand, 3'd6);
    kind = KIND_OTHER;
    tid  = 4'sd0;
    psid = 8'd0;
    case (codec_select)
      CODEC_H264: begin
        if (h0[4:0] < AVC_VCL_LIMIT) kind = KIND_VCL;
        else if (h0[4:0] == AVC_SPS) kind = KIND_SPS;
        else if (h0[4:0] == AVC_PPS) kind = KIND_PPS;
        else if (h0[4:0] == AVC_SPS_EXT) kind = KIND_SPS_EXT;
      end
      CODEC_H265: begin
        if (h0[7:1] < HEVC_VPS) kind = KIND_VCL;
        else if (h0[7:1] == HEVC_VPS) kind = KIND_VPS;
        else if (h0[7:1] == HEVC_SPS) kind = KIND_SPS;
        else if (h0[7:1] == HEVC_PPS) kind = KIND_PPS;
      end
      CODEC_H266: begin
        if (h1[7:3] < VVC_VCL_LIMIT) kind = KIND_VCL;
        else if (h1[7:3] == VVC_VPS) kind = KIND_VPS;
        else if (h1[7:3] == VVC_SPS) kind = KIND_SPS;
        else if (h1[7:3] == VVC_PPS) kind = KIND_PPS;
        else if (h1[7:3] == VVC_APS_A || h1[7:3] == VVC_APS_B) kind = KIND_APS;
        tid = $signed({1'b0, h1[2:0]} - 4'd1);
        if (kind == KIND_APS) psid = h2;
      end
      default: begin
        kind = KIND_OTHER;
      end
    endcase
  end

  // pick the next record of the head entry
  always_comb begin
    take_a   = head.vld_a && !sel;
    cand     = take_a ? head.rec_a : head.rec_b;
    is_last  = !take_a || !head.vld_b;
    load     = !q_empty && (!out_ch.valid || out_ch.ready);
    q_pop    = load && is_last;
    sel_next = load ? !is_last : sel;
  end

  // output register and pair position
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      sel          <= 1'b0;
    end else begin
      sel <= sel_next;
      if (load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.unit_start   <= cand.start;
      out_ch.unit_length  <= cand.length;
      out_ch.unit_kind    <= kind;
      out_ch.temporal_id  <= tid;
      out_ch.param_set_id <= psid;
      out_ch.last_of_run  <= is_last;
    end
  end

endmodule

[rtl/nal_unit_splitter_classifier.sv]
`timescale 1ns / 1ps
// nal_unit_splitter_classifier: top level, apb register, front/queue/back
// depends on nusc_pkg, nusc_byte_if, nusc_unit_if, nusc_front, nusc_queue, nusc_back
//
//   channel   dir  carries                                        handshake
//   in_ch     in   data_byte, end_of_stream                       valid/ready
//   out_ch    out  unit_start, unit_length, unit_kind,
//                  temporal_id, param_set_id, last_of_run         valid/ready
//   apb       in   codec_select at byte address 0                 psel/penable
//
// one byte is taken per cycle while the record queue (4 entries) has room
// a record reaches the output register through a queue slot after its closing byte
// a byte that closes two units puts two records in one queue entry
// synchronous reset clears all stream state, codec_select and the queue
// output stalls fill the queue, then input ready drops

module nal_unit_splitter_classifier import nusc_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  nusc_byte_if.sink   in_ch,
  nusc_unit_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] codec_select;
  logic       reg_wr;
  logic       q_full, q_empty, q_push, q_pop;
  rec_pair_t  q_wdata, q_rdata;

  // configuration register
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_select <= CODEC_H264;
    end else if (reg_wr && paddr[2] == REG_CODEC_SELECT) begin
      codec_select <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CODEC_SELECT) ? {30'd0, codec_select} : 32'd0;

  // byte scanner
  nusc_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_wdata)
  );

  // record queue
  nusc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // decode and output
  nusc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .codec_select (codec_select),
    .out_ch       (out_ch)
  );

  // no record right after reset
  a_idle_after_reset: assert property (@(posedge clk) (!rst && $past(rst)) |-> !out_ch.valid)
    else $error("output valid right after reset");

  // every reported unit spans at least two bytes
  a_min_length: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.unit_length >= 32'd2)
    else $error("unit shorter than two bytes");

  // ids only come from vvc headers
  a_ids_vvc_only: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && codec_select != CODEC_H266) |->
      (out_ch.temporal_id == 4'sd0 && out_ch.param_set_id == 8'd0))
    else $error("temporal or aps id set outside vvc");

  // aps id only on aps units
  a_psid_aps_only: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.param_set_id != 8'd0) |-> out_ch.unit_kind == KIND_APS)
    else $error("aps id on a non-aps unit");

endmodule
